/* rtl/core/speck_cbc_cipher_with_cbc_mac_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Speck CBC cipher with CBC-MAC
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SPECK_CBC_CIPHER_WITH_CBC_MAC_MACROS_SVH
`define SPECK_CBC_CIPHER_WITH_CBC_MAC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCMAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scmac: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCMAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scmac: next-cycle check failed");

`endif

/* rtl/core/scmac_pkg.sv */
// ----------------------------------------------------------------------------
// scmac_pkg
// Types, constants and Speck word helpers shared by the cipher block.
// ----------------------------------------------------------------------------
package scmac_pkg;

  localparam int WORD_W        = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int DEF_ROUND_CNT = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CIPHER_KEY_LOW  = 3'd0,
    CFG_CIPHER_KEY_HIGH = 3'd1,
    CFG_AUTH_KEY_LOW    = 3'd2,
    CFG_AUTH_KEY_HIGH   = 3'd3,
    CFG_IV_LOW          = 3'd4,
    CFG_IV_HIGH         = 3'd5,
    CFG_DIRECTION       = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_t;

  typedef enum logic [2:0] {
    ST_EXP_INIT,
    ST_EXP,
    ST_IDLE,
    ST_DATA,
    ST_MAC,
    ST_FINISH
  } state_t;

  function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
    return {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rol8(input logic [WORD_W-1:0] v);
    return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
  endfunction

  function automatic logic [WORD_W-1:0] ror3(input logic [WORD_W-1:0] v);
    return {v[2:0], v[WORD_W-1:3]};
  endfunction

  function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

endpackage

/* rtl/core/scmac_in_if.sv */
// ----------------------------------------------------------------------------
// scmac_in_if
// Input channel: one 128-bit block per request plus the message start flag.
// ----------------------------------------------------------------------------
interface scmac_in_if
  import scmac_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] in_word_low;
  logic [WORD_W-1:0] in_word_high;
  logic              message_start;

  modport source (output valid, output in_word_low, output in_word_high,
                  output message_start, input ready);
  modport sink   (input valid, input in_word_low, input in_word_high,
                  input message_start, output ready);
endinterface

/* rtl/core/scmac_out_if.sv */
// ----------------------------------------------------------------------------
// scmac_out_if
// Result channel: the output block and the running MAC per request.
// ----------------------------------------------------------------------------
interface scmac_out_if
  import scmac_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word_low;
  logic [WORD_W-1:0] out_word_high;
  logic [WORD_W-1:0] tag_low;
  logic [WORD_W-1:0] tag_high;

  modport source (output valid, output out_word_low, output out_word_high,
                  output tag_low, output tag_high, input ready);
  modport sink   (input valid, input out_word_low, input out_word_high,
                  input tag_low, input tag_high, output ready);
endinterface

/* rtl/core/scmac_ram.sv */
// ----------------------------------------------------------------------------
// scmac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scmac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/speck_cbc_cipher_with_cbc_mac.sv */
// ----------------------------------------------------------------------------
// speck_cbc_cipher_with_cbc_mac
// Speck128/128 CBC encryption or decryption with a Speck128/128 CBC-MAC
// kept over the ciphertext blocks.
// ----------------------------------------------------------------------------
// Usage: keys, IV and direction are written through the cfg_ port while no
// request is in flight. Each request on in_chan carries one block; setting
// message_start reloads the chain from the IV and clears the MAC first. Each
// request yields one result on out_chan holding the output block and the MAC
// after that block.
// After reset and after any key write both round key stores are expanded,
// one round key per cycle; in_chan.ready is low meanwhile.
// In decrypt mode the data and MAC rounds run side by side; in encrypt mode
// the MAC rounds follow the data rounds. A new request is accepted only
// once the previous one's result is in the output register. Each cipher has
// a single round unit, one round a cycle.
// Results sit in an output register; the next request is accepted while a
// result waits; a finished result stalls in place until the waiting one is taken.
// ----------------------------------------------------------------------------
`include "speck_cbc_cipher_with_cbc_mac_macros.svh"

module speck_cbc_cipher_with_cbc_mac
  import scmac_pkg::*;
#(
  parameter int ROUND_COUNT = DEF_ROUND_CNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_wdata,
  scmac_in_if.sink               in_chan,
  scmac_out_if.source            out_chan
);
  localparam int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ROUND_COUNT - 1);
  localparam logic [AW-1:0] EXP_LAST = AW'(ROUND_COUNT - 2);
  localparam logic [AW-1:0] PEN_IDX  = AW'(ROUND_COUNT - 2);

  state_t state_r, state_nxt;

  logic [WORD_W-1:0] ck_lo_r, ck_hi_r, ak_lo_r, ak_hi_r, iv_lo_r, iv_hi_r;
  dir_t              dir_r;

  logic [WORD_W-1:0] chain_lo_r, chain_hi_r, chain_lo_nxt, chain_hi_nxt;
  logic [WORD_W-1:0] tag_lo_r, tag_hi_r, tag_lo_nxt, tag_hi_nxt;
  logic [WORD_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [WORD_W-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic [WORD_W-1:0] ct_lo_r, ct_hi_r, ct_lo_nxt, ct_hi_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;

  logic [WORD_W-1:0] out_lo_r, out_hi_r, otag_lo_r, otag_hi_r;
  logic [WORD_W-1:0] out_lo_nxt, out_hi_nxt, otag_lo_nxt, otag_hi_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              key_wr, in_acc, last, out_load, is_dec;
  logic              ck_we, ak_we;
  logic [AW-1:0]     waddr, ck_raddr, ak_raddr;
  logic [WORD_W-1:0] ck_wdata, ak_wdata, ck_rd, ak_rd;

  logic              fwd;
  logic [WORD_W-1:0] dkey, mkey, sa, sb, sum, inv_b, dres_x, dres_y;
  logic [WORD_W-1:0] msum, mres_x, mres_y;
  logic [WORD_W-1:0] eff_chain_lo, eff_chain_hi, eff_tag_lo, eff_tag_hi;

  assign key_wr   = cfg_we && (cfg_index inside {CFG_CIPHER_KEY_LOW, CFG_CIPHER_KEY_HIGH,
                                                 CFG_AUTH_KEY_LOW, CFG_AUTH_KEY_HIGH});
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign last     = (cnt_r == LAST_IDX);
  assign is_dec   = (dir_r == DIR_DECRYPT);
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  // Data round unit: one shared adder serves forward, inverse and key rounds.
  assign fwd  = !(is_dec && state_r == ST_DATA);
  assign dkey = (state_r == ST_EXP) ? WORD_W'(cnt_r) : ck_rd;
  assign inv_b = ror3(y_r ^ x_r);
  assign sa   = fwd ? ror8(x_r) : (x_r ^ dkey);
  assign sb   = fwd ? y_r : ~inv_b;
  assign sum  = sa + sb + WORD_W'(!fwd);
  assign dres_x = fwd ? (sum ^ dkey) : rol8(sum);
  assign dres_y = fwd ? (rol3(y_r) ^ dres_x) : inv_b;

  // MAC round unit: forward rounds and the MAC key schedule.
  assign mkey   = (state_r == ST_EXP) ? WORD_W'(cnt_r) : ak_rd;
  assign msum   = ror8(mx_r) + my_r;
  assign mres_x = msum ^ mkey;
  assign mres_y = rol3(my_r) ^ mres_x;

  assign eff_chain_lo = in_chan.message_start ? iv_lo_r : chain_lo_r;
  assign eff_chain_hi = in_chan.message_start ? iv_hi_r : chain_hi_r;
  assign eff_tag_lo   = in_chan.message_start ? '0 : tag_lo_r;
  assign eff_tag_hi   = in_chan.message_start ? '0 : tag_hi_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EXP_INIT: state_nxt = key_wr ? ST_EXP_INIT : ST_EXP;
      ST_EXP: begin
        if (key_wr) begin
          state_nxt = ST_EXP_INIT;
        end else if (cnt_r == EXP_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (key_wr) begin
          state_nxt = ST_EXP_INIT;
        end else if (in_acc) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (last) begin
          state_nxt = is_dec ? ST_FINISH : ST_MAC;
        end
      end
      ST_MAC: begin
        if (last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_EXP_INIT;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    ck_we    = 1'b0;
    ak_we    = 1'b0;
    waddr    = '0;
    ck_wdata = dres_y;
    ak_wdata = mres_y;
    ck_raddr = '0;
    ak_raddr = '0;
    x_nxt    = x_r;
    y_nxt    = y_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    ct_lo_nxt = ct_lo_r;
    ct_hi_nxt = ct_hi_r;
    chain_lo_nxt = chain_lo_r;
    chain_hi_nxt = chain_hi_r;
    tag_lo_nxt   = tag_lo_r;
    tag_hi_nxt   = tag_hi_r;
    cnt_nxt      = cnt_r;
    out_lo_nxt   = out_lo_r;
    out_hi_nxt   = out_hi_r;
    otag_lo_nxt  = otag_lo_r;
    otag_hi_nxt  = otag_hi_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_EXP_INIT: begin
        x_nxt    = ck_lo_r;
        y_nxt    = ck_hi_r;
        mx_nxt   = ak_lo_r;
        my_nxt   = ak_hi_r;
        ck_we    = 1'b1;
        ak_we    = 1'b1;
        ck_wdata = ck_hi_r;
        ak_wdata = ak_hi_r;
        cnt_nxt  = '0;
      end
      ST_EXP: begin
        x_nxt   = dres_x;
        y_nxt   = dres_y;
        mx_nxt  = mres_x;
        my_nxt  = mres_y;
        ck_we   = 1'b1;
        ak_we   = 1'b1;
        waddr   = cnt_r + 1'b1;
        cnt_nxt = (cnt_r == EXP_LAST) ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        ck_raddr = is_dec ? LAST_IDX : '0;
        if (in_acc) begin
          chain_lo_nxt = eff_chain_lo;
          chain_hi_nxt = eff_chain_hi;
          tag_lo_nxt   = eff_tag_lo;
          tag_hi_nxt   = eff_tag_hi;
          ct_lo_nxt    = in_chan.in_word_low;
          ct_hi_nxt    = in_chan.in_word_high;
          cnt_nxt      = '0;
          if (is_dec) begin
            x_nxt  = in_chan.in_word_low;
            y_nxt  = in_chan.in_word_high;
            mx_nxt = eff_tag_lo ^ in_chan.in_word_low;
            my_nxt = eff_tag_hi ^ in_chan.in_word_high;
          end else begin
            x_nxt = in_chan.in_word_low ^ eff_chain_lo;
            y_nxt = in_chan.in_word_high ^ eff_chain_hi;
          end
        end
      end
      ST_DATA: begin
        x_nxt = dres_x;
        y_nxt = dres_y;
        if (!last) begin
          ck_raddr = is_dec ? (PEN_IDX - cnt_r) : (cnt_r + 1'b1);
        end
        if (is_dec) begin
          mx_nxt = mres_x;
          my_nxt = mres_y;
          if (!last) begin
            ak_raddr = cnt_r + 1'b1;
          end
        end else if (last) begin
          chain_lo_nxt = dres_x;
          chain_hi_nxt = dres_y;
          mx_nxt       = tag_lo_r ^ dres_x;
          my_nxt       = tag_hi_r ^ dres_y;
        end
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
      end
      ST_MAC: begin
        mx_nxt = mres_x;
        my_nxt = mres_y;
        if (!last) begin
          ak_raddr = cnt_r + 1'b1;
        end
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
      end
      ST_FINISH: begin
        if (out_load) begin
          out_lo_nxt    = is_dec ? (x_r ^ chain_lo_r) : x_r;
          out_hi_nxt    = is_dec ? (y_r ^ chain_hi_r) : y_r;
          otag_lo_nxt   = mx_r;
          otag_hi_nxt   = my_r;
          tag_lo_nxt    = mx_r;
          tag_hi_nxt    = my_r;
          out_valid_nxt = 1'b1;
          if (is_dec) begin
            chain_lo_nxt = ct_lo_r;
            chain_hi_nxt = ct_hi_r;
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXP_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ck_lo_r     <= '0;
      ck_hi_r     <= '0;
      ak_lo_r     <= '0;
      ak_hi_r     <= '0;
      iv_lo_r     <= '0;
      iv_hi_r     <= '0;
      dir_r       <= DIR_ENCRYPT;
      chain_lo_r  <= '0;
      chain_hi_r  <= '0;
      tag_lo_r    <= '0;
      tag_hi_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      chain_lo_r  <= chain_lo_nxt;
      chain_hi_r  <= chain_hi_nxt;
      tag_lo_r    <= tag_lo_nxt;
      tag_hi_r    <= tag_hi_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CIPHER_KEY_LOW:  ck_lo_r <= cfg_wdata;
          CFG_CIPHER_KEY_HIGH: ck_hi_r <= cfg_wdata;
          CFG_AUTH_KEY_LOW:    ak_lo_r <= cfg_wdata;
          CFG_AUTH_KEY_HIGH:   ak_hi_r <= cfg_wdata;
          CFG_IV_LOW:          iv_lo_r <= cfg_wdata;
          CFG_IV_HIGH:         iv_hi_r <= cfg_wdata;
          CFG_DIRECTION:       dir_r   <= dir_t'(cfg_wdata[0]);
          default:             dir_r   <= dir_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    ct_lo_r   <= ct_lo_nxt;
    ct_hi_r   <= ct_hi_nxt;
    out_lo_r  <= out_lo_nxt;
    out_hi_r  <= out_hi_nxt;
    otag_lo_r <= otag_lo_nxt;
    otag_hi_r <= otag_hi_nxt;
  end

  scmac_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUND_COUNT)
  ) u_cipher_keys (
    .clk   (clk),
    .we    (ck_we),
    .waddr (waddr),
    .wdata (ck_wdata),
    .raddr (ck_raddr),
    .rdata (ck_rd)
  );

  scmac_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUND_COUNT)
  ) u_auth_keys (
    .clk   (clk),
    .we    (ak_we),
    .waddr (waddr),
    .wdata (ak_wdata),
    .raddr (ak_raddr),
    .rdata (ak_rd)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_word_low  = out_lo_r;
  assign out_chan.out_word_high = out_hi_r;
  assign out_chan.tag_low       = otag_lo_r;
  assign out_chan.tag_high      = otag_hi_r;

  `SCMAC_ASSERT_NEXT(a_accept_starts_rounds, in_acc, state_r == ST_DATA && cnt_r == '0)
  `SCMAC_ASSERT_NEXT(a_finish_loads_output, out_load, out_valid_r && state_r == ST_IDLE)
  `SCMAC_ASSERT_SAME(a_counter_in_range, 1'b1, cnt_r <= LAST_IDX)

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for speck_cbc_cipher_with_cbc_mac
// A table of directed requests and register writes is followed by random
// phases of keys, IVs and directions, each carrying messages of random
// length. Every accepted request is run through a Speck128/128 CBC and
// CBC-MAC predictor, and every result is compared field by field with the
// oldest prediction. Both channels idle at random, and once the result side
// holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scmac_pkg::*;

  localparam int ROUNDS        = DEF_ROUND_CNT;
  localparam int RANDOM_TARGET = 1500;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 2 * ROUNDS + 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_LIMIT  = 10;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t round_keys_t [ROUNDS];

  typedef struct packed {
    word_t hi;
    word_t lo;
  } block_t;

  typedef struct packed {
    word_t out_lo;
    word_t out_hi;
    word_t tag_lo;
    word_t tag_hi;
  } result_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_BLOCK,
    ROW_BLOCK_KNOWN
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_INDEX_W-1:0] index;
    logic             start;
    word_t            a;
    word_t            b;
    word_t            want_lo;
    word_t            want_hi;
  } row_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  localparam word_t ZERO      = '0;
  localparam word_t ONES      = '1;
  localparam word_t TOP_BIT   = 64'h8000_0000_0000_0000;
  localparam word_t EDGE_BITS = 64'h8000_0000_0000_0001;
  localparam word_t FIVES     = 64'h5555_5555_5555_5555;
  localparam word_t TENS      = 64'haaaa_aaaa_aaaa_aaaa;
  localparam word_t RAMP_UP   = 64'h0123_4567_89ab_cdef;
  localparam word_t RAMP_DOWN = 64'hfedc_ba98_7654_3210;
  localparam word_t DIR_NOISE = 64'hffff_ffff_ffff_fffe;

  // Published Speck128/128 test vector, x as the low word.
  localparam word_t VEC_KEY_L = 64'h0f0e_0d0c_0b0a_0908;
  localparam word_t VEC_KEY_K = 64'h0706_0504_0302_0100;
  localparam word_t VEC_PT_X  = 64'h6c61_7669_7571_6520;
  localparam word_t VEC_PT_Y  = 64'h7469_2065_6461_6d20;
  localparam word_t VEC_CT_X  = 64'ha65d_9851_7978_3265;
  localparam word_t VEC_CT_Y  = 64'h7860_fedf_5c57_0d18;

  localparam int DIRECTED_ROWS = 31;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ONES,      ONES,      ZERO,     ZERO},
    '{ROW_REG,         CFG_CIPHER_KEY_LOW,  1'b0, VEC_KEY_L, ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_CIPHER_KEY_HIGH, 1'b0, VEC_KEY_K, ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK_KNOWN, CFG_UNUSED_INDEX,    1'b1, VEC_PT_X,  VEC_PT_Y,  VEC_CT_X, VEC_CT_Y},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ZERO,      ONES,      ZERO,     ZERO},
    '{ROW_REG,         CFG_UNUSED_INDEX,    1'b0, ONES,      ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ONES,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_IV_LOW,          1'b0, ONES,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_IV_HIGH,         1'b0, EDGE_BITS, ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, RAMP_UP,   RAMP_DOWN, ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b1, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_AUTH_KEY_LOW,    1'b0, ONES,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_AUTH_KEY_HIGH,   1'b0, ONES,      ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, TOP_BIT,   EDGE_BITS, ZERO,     ZERO},
    '{ROW_REG,         CFG_DIRECTION,       1'b0, 64'(DIR_DECRYPT), ZERO, ZERO,   ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ONES,      ONES,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_IV_LOW,          1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_IV_HIGH,         1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK_KNOWN, CFG_UNUSED_INDEX,    1'b1, VEC_CT_X,  VEC_CT_Y,  VEC_PT_X, VEC_PT_Y},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, VEC_PT_X,  VEC_PT_Y,  ZERO,     ZERO},
    '{ROW_REG,         CFG_CIPHER_KEY_LOW,  1'b0, ONES,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_CIPHER_KEY_HIGH, 1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, FIVES,     TENS,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b1, TENS,      FIVES,     ZERO,     ZERO},
    '{ROW_REG,         CFG_DIRECTION,       1'b0, DIR_NOISE, ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b0, ZERO,      ONES,      ZERO,     ZERO},
    '{ROW_REG,         CFG_AUTH_KEY_LOW,    1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_REG,         CFG_AUTH_KEY_HIGH,   1'b0, ZERO,      ZERO,      ZERO,     ZERO},
    '{ROW_BLOCK,       CFG_UNUSED_INDEX,    1'b1, ONES,      ONES,      ZERO,     ZERO}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_wdata;

  scmac_in_if  in_bus ();
  scmac_out_if out_bus ();

  speck_cbc_cipher_with_cbc_mac #(
    .ROUND_COUNT (ROUNDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  // Predictor state, mirroring the registers and the chaining state.
  word_t       cipher_key_lo, cipher_key_hi;
  word_t       auth_key_lo, auth_key_hi;
  block_t      iv_blk;
  dir_t        mode;
  block_t      chain_blk;
  block_t      mac_blk;
  round_keys_t cipher_keys;
  round_keys_t auth_keys;

  result_t awaited_blocks [$];
  int      mismatch_count;
  int      burst_left;
  int      hold_asked;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic round_keys_t expand_schedule(input word_t lo, input word_t hi);
    round_keys_t rk;
    word_t       l;
    word_t       k;
    l = lo;
    k = hi;
    rk[0] = k;
    for (int i = 0; i < ROUNDS - 1; i++) begin
      l = (rotr(l, 8) + k) ^ word_t'(i);
      k = rotl(k, 3) ^ l;
      rk[i + 1] = k;
    end
    return rk;
  endfunction

  function automatic block_t speck_forward(input round_keys_t rk, input block_t blk);
    word_t x;
    word_t y;
    x = blk.lo;
    y = blk.hi;
    for (int i = 0; i < ROUNDS; i++) begin
      x = (rotr(x, 8) + y) ^ rk[i];
      y = rotl(y, 3) ^ x;
    end
    return '{hi: y, lo: x};
  endfunction

  function automatic block_t speck_inverse(input round_keys_t rk, input block_t blk);
    word_t x;
    word_t y;
    x = blk.lo;
    y = blk.hi;
    for (int i = ROUNDS - 1; i >= 0; i--) begin
      y = rotr(y ^ x, 3);
      x = rotl((x ^ rk[i]) - y, 8);
    end
    return '{hi: y, lo: x};
  endfunction

  function automatic void reset_predictor();
    cipher_key_lo = '0;
    cipher_key_hi = '0;
    auth_key_lo   = '0;
    auth_key_hi   = '0;
    iv_blk        = '0;
    mode          = DIR_ENCRYPT;
    chain_blk     = '0;
    mac_blk       = '0;
    cipher_keys   = expand_schedule('0, '0);
    auth_keys     = expand_schedule('0, '0);
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx, input word_t value);
    case (idx)
      CFG_CIPHER_KEY_LOW:  cipher_key_lo = value;
      CFG_CIPHER_KEY_HIGH: cipher_key_hi = value;
      CFG_AUTH_KEY_LOW:    auth_key_lo = value;
      CFG_AUTH_KEY_HIGH:   auth_key_hi = value;
      CFG_IV_LOW:          iv_blk.lo = value;
      CFG_IV_HIGH:         iv_blk.hi = value;
      CFG_DIRECTION:       mode = dir_t'(value[0]);
      default: ;
    endcase
    if (idx == CFG_CIPHER_KEY_LOW || idx == CFG_CIPHER_KEY_HIGH) begin
      cipher_keys = expand_schedule(cipher_key_lo, cipher_key_hi);
    end
    if (idx == CFG_AUTH_KEY_LOW || idx == CFG_AUTH_KEY_HIGH) begin
      auth_keys = expand_schedule(auth_key_lo, auth_key_hi);
    end
  endfunction

  function automatic result_t predict_cbc_block(input word_t lo, input word_t hi,
                                                input logic start);
    block_t  blk;
    block_t  ct;
    block_t  plain;
    result_t res;
    if (start) begin
      chain_blk = iv_blk;
      mac_blk   = '0;
    end
    blk = '{hi: hi, lo: lo};
    if (mode == DIR_ENCRYPT) begin
      ct    = speck_forward(cipher_keys, block_t'(blk ^ chain_blk));
      plain = ct;
    end else begin
      ct    = blk;
      plain = block_t'(speck_inverse(cipher_keys, blk) ^ chain_blk);
    end
    chain_blk  = ct;
    mac_blk    = speck_forward(auth_keys, block_t'(mac_blk ^ ct));
    res.out_lo = plain.lo;
    res.out_hi = plain.hi;
    res.tag_lo = mac_blk.lo;
    res.tag_hi = mac_blk.hi;
    return res;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return ZERO;
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    apply_reg(idx, value);
  endtask

  task automatic push_block(input word_t lo, input word_t hi, input logic start,
                            input bit known, input word_t known_lo, input word_t known_hi);
    result_t res;
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_bus.valid         <= 1'b1;
    in_bus.in_word_low   <= lo;
    in_bus.in_word_high  <= hi;
    in_bus.message_start <= start;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    res = predict_cbc_block(lo, hi, start);
    if (known) begin
      res.out_lo = known_lo;
      res.out_hi = known_hi;
    end
    awaited_blocks.push_back(res);
    burst_left--;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : receiver
    int hold_served;
    int mode_sel;
    int run;
    hold_served = 0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode_sel = $urandom_range(0, 3);
        run      = $urandom_range(4, 40);
        repeat (run) begin
          case (mode_sel)
            0:       out_bus.ready <= 1'b1;
            1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
            2:       out_bus.ready <= 1'($urandom_range(0, 1));
            default: out_bus.ready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    word_t   got [4];
    word_t   exp_w [4];
    string   names [4];
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (awaited_blocks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: %h %h tag %h %h", out_bus.out_word_low,
                   out_bus.out_word_high, out_bus.tag_low, out_bus.tag_high);
        end
      end else begin
        want  = awaited_blocks.pop_front();
        names = '{"out_word_low", "out_word_high", "tag_low", "tag_high"};
        got   = '{out_bus.out_word_low, out_bus.out_word_high,
                  out_bus.tag_low, out_bus.tag_high};
        exp_w = '{want.out_lo, want.out_hi, want.tag_lo, want.tag_hi};
        for (int f = 0; f < 4; f++) begin
          if (got[f] !== exp_w[f]) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("mismatch in %s: expected %h, got %h", names[f], exp_w[f], got[f]);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    row_t row;
    bit   cfg_open;
    bit   hold_done;
    int   random_sent;
    int   msg_count;
    int   msg_len;
    logic start;

    mismatch_count = 0;
    burst_left     = 0;
    hold_asked     = 0;
    cfg_open       = 1'b0;
    hold_done      = 1'b0;
    random_sent    = 0;
    reset_predictor();

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_CIPHER_KEY_LOW;
    cfg_wdata            <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.in_word_low   <= '0;
    in_bus.in_word_high  <= '0;
    in_bus.message_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      if (row.kind == ROW_REG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(row.index, row.a);
      end else begin
        if (cfg_open) begin
          cfg_we  <= 1'b0;
          cfg_open = 1'b0;
        end
        push_block(row.a, row.b, row.start, row.kind == ROW_BLOCK_KNOWN,
                   row.want_lo, row.want_hi);
      end
    end

    while (random_sent < RANDOM_TARGET) begin
      settle();
      for (int idx = 0; idx < 8; idx++) begin
        if ($urandom_range(0, 2) == 0) begin
          write_reg(CFG_INDEX_W'(idx), pick_word());
        end
      end
      cfg_we <= 1'b0;
      msg_count = $urandom_range(1, 4);
      repeat (msg_count) begin
        msg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
        for (int n = 0; n < msg_len; n++) begin
          if (n == 0) begin
            start = ($urandom_range(0, 7) != 0);
          end else begin
            start = ($urandom_range(0, 19) == 0);
          end
          if (!hold_done && random_sent >= RANDOM_TARGET / 2) begin
            hold_done = 1'b1;
            hold_asked++;
            burst_left = 60;
          end
          push_block(pick_word(), pick_word(), start, 1'b0, ZERO, ZERO);
          random_sent++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_blocks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
